// ----- hw/rtl/msort_pkg.sv -----
// ----------------------------------------------------------------------------
// msort_pkg
// Shared sizes, types and the job format for the merge sorter.
// ----------------------------------------------------------------------------
package msort_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int VALUE_WIDTH  = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int SUM_W        = CNT_W + 1;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [SUM_W-1:0]              sum_t;

  // One classified input transaction as handed from the front to the back.
  typedef struct packed {
    logic   store;     // value goes into the element store
    logic   close;     // set is complete, sort and emit
    idx_t   index;
    value_t value;
    cnt_t   count;     // element count of the set when close is set
    logic   overflow;
  } job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

endpackage

// ----- hw/rtl/msort_in_if.sv -----
// ----------------------------------------------------------------------------
// msort_in_if
// Input channel of the merge sorter: one value per transaction.
// ----------------------------------------------------------------------------
interface msort_in_if;
  logic                 valid;
  logic                 ready;
  msort_pkg::value_t    value;
  logic                 last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- hw/rtl/msort_out_if.sv -----
// ----------------------------------------------------------------------------
// msort_out_if
// Output channel of the merge sorter: one sorted value per transaction.
// ----------------------------------------------------------------------------
interface msort_out_if;
  logic                 valid;
  logic                 ready;
  msort_pkg::value_t    sorted_value;
  logic                 end_of_set;
  logic                 overflow;

  modport source (output valid, output sorted_value, output end_of_set,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input end_of_set,
                  input overflow, output ready);
endinterface

// ----- hw/rtl/msort_front.sv -----
// ----------------------------------------------------------------------------
// msort_front
// Accepts input transactions, assigns store slots and detects overflow.
// ----------------------------------------------------------------------------
module msort_front (
  input  logic                clk,
  input  logic                rst,
  msort_in_if.sink            items,
  input  logic                queue_full,
  output logic                push,
  output msort_pkg::job_t     job
);

  msort_pkg::cnt_t count;
  logic            dropped;
  logic            has_room;

  assign has_room    = count < msort_pkg::CNT_W'(msort_pkg::MAX_ELEMENTS);
  assign items.ready = !queue_full;
  assign push        = items.valid && items.ready;

  always_comb begin
    job.store    = has_room;
    job.close    = items.last;
    job.index    = count[msort_pkg::IDX_W-1:0];
    job.value    = items.value;
    job.count    = has_room ? count + msort_pkg::CNT_W'(1) : count;
    job.overflow = dropped || !has_room;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (push) begin
      if (items.last) begin
        count   <= '0;
        dropped <= 1'b0;
      end else if (has_room) begin
        count <= count + msort_pkg::CNT_W'(1);
      end else begin
        dropped <= 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/msort_queue.sv -----
// ----------------------------------------------------------------------------
// msort_queue
// Short first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module msort_queue (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  input  msort_pkg::job_t           push_job,
  input  logic                      pop,
  output msort_pkg::job_t           head,
  output msort_pkg::queue_status_t  status
);

  msort_pkg::job_t                 entries [msort_pkg::QUEUE_DEPTH];
  logic [msort_pkg::QPTR_W-1:0]    wr_ptr;
  logic [msort_pkg::QPTR_W-1:0]    rd_ptr;
  logic [msort_pkg::QPTR_W:0]      level;

  assign head         = entries[rd_ptr];
  assign status.empty = level == '0;
  assign status.full  = level == (msort_pkg::QPTR_W + 1)'(msort_pkg::QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + msort_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + msort_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        level <= level + (msort_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        level <= level - (msort_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/msort_back.sv -----
// ----------------------------------------------------------------------------
// msort_back
// Stores values, sorts a closed set by bottom-up merge passes between two
// memories and emits the sorted set.
// ----------------------------------------------------------------------------
module msort_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               job_valid,
  input  msort_pkg::job_t    job,
  output logic               job_ready,
  msort_out_if.source        results
);

  typedef enum logic [6:0] {
    S_IDLE        = 7'b0000001,
    S_PASS_START  = 7'b0000010,
    S_BLOCK_START = 7'b0000100,
    S_READ        = 7'b0001000,
    S_MERGE       = 7'b0010000,
    S_EMIT_RD     = 7'b0100000,
    S_EMIT        = 7'b1000000
  } state_t;

  state_t            state;
  logic              sel;        // 0: current run data lives in mem0
  logic              ovf;
  msort_pkg::cnt_t   n;
  msort_pkg::sum_t   width;
  msort_pkg::cnt_t   lo;
  msort_pkg::cnt_t   mid;
  msort_pkg::cnt_t   hi;
  msort_pkg::cnt_t   i;
  msort_pkg::cnt_t   j;
  msort_pkg::cnt_t   k;

  msort_pkg::value_t mem0 [msort_pkg::MAX_ELEMENTS];
  msort_pkg::value_t mem1 [msort_pkg::MAX_ELEMENTS];
  msort_pkg::value_t rd0a, rd0b, rd1a, rd1b;

  msort_pkg::idx_t   ra, rb, wa;
  logic              rd_en;
  logic              we0, we1;
  logic              take_left;
  msort_pkg::value_t a_val, b_val, merge_val, wd0;
  msort_pkg::sum_t   n_ext, lo_w, lo_2w;
  msort_pkg::cnt_t   k_inc;
  logic              pop;

  assign pop       = (state == S_IDLE) && job_valid;
  assign job_ready = state == S_IDLE;

  assign n_ext = {1'b0, n};
  assign lo_w  = {1'b0, lo} + width;
  assign lo_2w = {1'b0, lo} + (width << 1);
  assign k_inc = k + msort_pkg::CNT_W'(1);

  assign a_val = sel ? rd1a : rd0a;
  assign b_val = sel ? rd1b : rd0b;

  // Left is taken only when strictly smaller, so equal values favor the right run.
  assign take_left = (i < mid) && ((j >= hi) || (a_val < b_val));
  assign merge_val = take_left ? a_val : b_val;

  assign rd_en = (state == S_READ) || (state == S_EMIT_RD);
  assign ra    = (state == S_EMIT_RD) ? k[msort_pkg::IDX_W-1:0] : i[msort_pkg::IDX_W-1:0];
  assign rb    = j[msort_pkg::IDX_W-1:0];

  assign we0 = (pop && job.store) || ((state == S_MERGE) && sel);
  assign we1 = (state == S_MERGE) && !sel;
  assign wa  = pop ? job.index : k[msort_pkg::IDX_W-1:0];
  assign wd0 = pop ? job.value : merge_val;

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wa] <= wd0;
    end
    if (we1) begin
      mem1[wa] <= merge_val;
    end
    if (rd_en) begin
      rd0a <= mem0[ra];
      rd0b <= mem0[rb];
      rd1a <= mem1[ra];
      rd1b <= mem1[rb];
    end
  end

  assign results.valid        = state == S_EMIT;
  assign results.sorted_value = a_val;
  assign results.end_of_set   = k_inc == n;
  assign results.overflow     = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
      ovf   <= 1'b0;
      n     <= '0;
      width <= '0;
      lo    <= '0;
      mid   <= '0;
      hi    <= '0;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pop && job.close) begin
            n     <= job.count;
            ovf   <= job.overflow;
            sel   <= 1'b0;
            width <= msort_pkg::SUM_W'(1);
            state <= S_PASS_START;
          end
        end
        S_PASS_START: begin
          if (width >= n_ext) begin
            k     <= '0;
            state <= S_EMIT_RD;
          end else begin
            lo    <= '0;
            state <= S_BLOCK_START;
          end
        end
        S_BLOCK_START: begin
          mid   <= (lo_w < n_ext) ? lo_w[msort_pkg::CNT_W-1:0] : n;
          hi    <= (lo_2w < n_ext) ? lo_2w[msort_pkg::CNT_W-1:0] : n;
          j     <= (lo_w < n_ext) ? lo_w[msort_pkg::CNT_W-1:0] : n;
          i     <= lo;
          k     <= lo;
          state <= S_READ;
        end
        S_READ: begin
          state <= S_MERGE;
        end
        S_MERGE: begin
          if (take_left) begin
            i <= i + msort_pkg::CNT_W'(1);
          end else begin
            j <= j + msort_pkg::CNT_W'(1);
          end
          k <= k_inc;
          if (k_inc == hi) begin
            if (lo_2w >= n_ext) begin
              sel   <= !sel;
              width <= width << 1;
              state <= S_PASS_START;
            end else begin
              lo    <= lo_2w[msort_pkg::CNT_W-1:0];
              state <= S_BLOCK_START;
            end
          end else begin
            state <= S_READ;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (results.ready) begin
            if (k_inc == n) begin
              state <= S_IDLE;
            end else begin
              k     <= k_inc;
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hw/rtl/merge_sorter.sv -----
// ----------------------------------------------------------------------------
// merge_sorter
// Collects signed values into a set and emits the set in ascending order.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Payload                                 Transaction
//   items     in         value, last                             one element
//   results   out        sorted_value, end_of_set, overflow      one sorted element
//
// Loading takes one element per cycle while the queue has room; the front keeps accepting into a
// four-entry queue while the back sorts or emits.
// A set of n elements sorts in ceil(log2 n) passes; each pass opens with a
// pass-start step and each merged block pair with a block-start step, and every
// element is read and then merged around the registered memory read; each
// result is likewise read from memory before it is offered.
// Reset is synchronous and needs no clearing pass; a stall on results holds
// the back, and the front stalls only when the queue is full.
module merge_sorter (
  input  logic          clk,
  input  logic          rst,
  msort_in_if.sink      items,
  msort_out_if.source   results
);

  logic                     push;
  logic                     pop;
  logic                     pop_ready;
  msort_pkg::job_t          push_job;
  msort_pkg::job_t          head;
  msort_pkg::queue_status_t q_status;

  msort_front u_front (
    .clk        (clk),
    .rst        (rst),
    .items      (items),
    .queue_full (q_status.full),
    .push       (push),
    .job        (push_job)
  );

  msort_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  msort_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (!q_status.empty),
    .job       (head),
    .job_ready (pop_ready),
    .results   (results)
  );

  assign pop = pop_ready && !q_status.empty;

`ifndef NO_ASSERTIONS
  // The queue level can never be both zero and at its depth.
  a_queue_status: assert property (@(posedge clk) disable iff (rst)
    !(q_status.full && q_status.empty))
    else $error("queue reports full and empty together");

  // A pushed job is visible to the back in the next cycle.
  a_push_visible: assert property (@(posedge clk) disable iff (rst)
    push |=> !q_status.empty)
    else $error("queue empty right after a push");

  // After the final result of a set is taken the back returns to idle.
  a_set_done: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.ready && results.end_of_set) |=> !results.valid)
    else $error("result offered right after the end of a set");
`endif

endmodule

// ----- tb/tb_merge_sorter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_merge_sorter
// Self-checking testbench for the merge sorter. Sets of signed values are
// streamed in, a scoreboard sorts each closed set the same way the block
// does, and every sorted result is checked in order. This covers full sets,
// sets that overflow the store, and random idling on both channels.
// ----------------------------------------------------------------------------
module tb_merge_sorter;

  localparam int unsigned CYCLE_LIMIT      = 200000;
  localparam int unsigned DRAIN_CYCLES     = 200;
  localparam int unsigned SINK_HOLD_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS      = 60;
  localparam int unsigned DIRECTED_COUNT   = 24;

  typedef enum int {VAL_FULL, VAL_NARROW, VAL_EXTREME} value_mix_e;
  typedef enum int {PH_FREE, PH_SPARSE_SENDER, PH_SLOW_RECEIVER, PH_MIXED} idle_phase_e;

  typedef struct packed {
    msort_pkg::value_t value;
    logic              end_of_set;
    logic              overflow;
  } sorted_item_t;

  // Extremes, duplicates, presorted and reversed sets, one element per entry.
  localparam msort_pkg::value_t DIRECTED_VALUES [DIRECTED_COUNT] = '{
    32'h8000_0000,
    32'h7FFF_FFFF,
    32'h7FFF_FFFF, 32'h8000_0000, 0, -1, 1,
    7, -3, 7, 7, -3, 0,
    -2, -1, 0, 1,
    5, 4, 3, 2, 1,
    0, 0
  };
  localparam bit DIRECTED_LAST [DIRECTED_COUNT] = '{
    1,
    1,
    0, 0, 0, 0, 1,
    0, 0, 0, 0, 0, 1,
    0, 0, 0, 1,
    0, 0, 0, 0, 1,
    0, 1
  };

  class sort_scoreboard;
    msort_pkg::value_t open_set[$];
    bit                dropped;
    sorted_item_t      sorted_due[$];
    int unsigned       mismatches;
    int unsigned       items_seen;
    int unsigned       results_seen;
    int unsigned       sets_closed;
    int unsigned       overflow_sets;

    // Collects one accepted input; a closing transaction sorts the set.
    function void note_item(msort_pkg::value_t v, logic last);
      msort_pkg::value_t bank [2][msort_pkg::MAX_ELEMENTS];
      sorted_item_t      item;
      int                n, width, lo, mid, hi, i, j, k, s;
      items_seen++;
      if (open_set.size() < msort_pkg::MAX_ELEMENTS) open_set.push_back(v);
      else dropped = 1'b1;
      if (!last) return;
      n = open_set.size();
      for (i = 0; i < n; i++) bank[0][i] = open_set[i];
      s = 0;
      for (width = 1; width < n; width *= 2) begin
        for (lo = 0; lo < n; lo += 2 * width) begin
          mid = (lo + width < n) ? lo + width : n;
          hi  = (lo + 2 * width < n) ? lo + 2 * width : n;
          i = lo;
          j = mid;
          for (k = lo; k < hi; k++) begin
            // The left run wins only when strictly smaller.
            if (i < mid && (j >= hi || bank[s][i] < bank[s][j])) begin
              bank[1-s][k] = bank[s][i];
              i++;
            end else begin
              bank[1-s][k] = bank[s][j];
              j++;
            end
          end
        end
        s = 1 - s;
      end
      for (k = 0; k < n; k++) begin
        item.value      = bank[s][k];
        item.end_of_set = (k == n - 1);
        item.overflow   = dropped;
        sorted_due.push_back(item);
      end
      sets_closed++;
      if (dropped) overflow_sets++;
      open_set.delete();
      dropped = 1'b0;
    endfunction

    function void check_result(msort_pkg::value_t v, logic eos, logic ovf);
      sorted_item_t want;
      results_seen++;
      if (sorted_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d end_of_set %b overflow %b",
                   v, eos, ovf);
        return;
      end
      want = sorted_due.pop_front();
      if (v !== want.value || eos !== want.end_of_set || ovf !== want.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: expected %0d/%b/%b, got %0d/%b/%b",
                   want.value, want.end_of_set, want.overflow, v, eos, ovf);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  msort_in_if  items_ch ();
  msort_out_if results_ch ();

  merge_sorter dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  sort_scoreboard board = new();

  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  bit          hold_request   = 1'b0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = SINK_HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (rst) begin
      results_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready)
      board.check_result(results_ch.sorted_value, results_ch.end_of_set,
                         results_ch.overflow);
  end

  initial begin
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still due",
             cycle_count, board.sorted_due.size());
    $display("merge_sorter test failed");
    $finish;
  end

  // Offers one value and returns once the transaction has been accepted.
  task automatic send_item(input msort_pkg::value_t v, input logic last);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.value <= v;
    items_ch.last  <= last;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    board.note_item(v, last);
  endtask

  task automatic send_random_set(input int unsigned n);
    msort_pkg::value_t v;
    value_mix_e        mix;
    mix = value_mix_e'($urandom_range(2));
    for (int unsigned k = 0; k < n; k++) begin
      case (mix)
        VAL_FULL: v = msort_pkg::value_t'($urandom);
        VAL_NARROW: v = msort_pkg::value_t'($urandom_range(6)) - msort_pkg::value_t'(3);
        default: begin
          case ($urandom_range(4))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = 0;
            3: v = -1;
            default: v = 1;
          endcase
        end
      endcase
      send_item(v, k == n - 1);
    end
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned n;
    items_ch.valid = 1'b0;
    items_ch.value = '0;
    items_ch.last  = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int d = 0; d < DIRECTED_COUNT; d++)
      send_item(DIRECTED_VALUES[d], DIRECTED_LAST[d]);

    for (int p = PH_FREE; p <= PH_MIXED; p++) begin
      case (idle_phase_e'(p))
        PH_FREE: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        PH_SPARSE_SENDER: begin
          src_idle_pct   = 73;
          sink_stall_pct = 0;
        end
        PH_SLOW_RECEIVER: begin
          src_idle_pct   = 0;
          sink_stall_pct = 73;
        end
        default: begin
          src_idle_pct   = 16;
          sink_stall_pct = 16;
        end
      endcase
      phase_start = board.items_seen;
      // A completely full store, and later a set whose tail is dropped.
      if (p == PH_SPARSE_SENDER) send_random_set(msort_pkg::MAX_ELEMENTS);
      if (p == PH_SLOW_RECEIVER) send_random_set(msort_pkg::MAX_ELEMENTS + 3);
      while (board.items_seen - phase_start < PHASE_ITEMS) begin
        n = ($urandom_range(15) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
        send_random_set(n);
      end
    end

    // The receiver holds off while the sender keeps pushing, so the input
    // queue fills and the block has to stall its input channel.
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_request   = 1'b1;
    repeat (4) send_random_set(10);
    items_ch.valid <= 1'b0;

    while (board.sorted_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sorted %0d sets (%0d with dropped elements) from %0d items into %0d results.",
             board.sets_closed, board.overflow_sets, board.items_seen, board.results_seen);
    $display("Traffic ran free, with a sparse sender, a stalling receiver, both,");
    $display("and one long hold-off of the receiver.");
    if (board.mismatches == 0 && board.sorted_due.size() == 0) begin
      $display("merge_sorter test passed");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("merge_sorter test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/msort_pkg.sv
hw/rtl/msort_in_if.sv
hw/rtl/msort_out_if.sv
hw/rtl/msort_front.sv
hw/rtl/msort_queue.sv
hw/rtl/msort_back.sv
hw/rtl/merge_sorter.sv
tb/tb_merge_sorter.sv
